// ===== sv/cilst_pkg.sv =====
package cilst_pkg;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned COUNT_W = 7;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_GET    = 2'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] count;
    } t_out_word;

endpackage

// ===== sv/cilst_ram.sv =====
module cilst_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/compacting_indexed_list_store.sv =====
// channel | valid        | ready        | word
// in      | i_in_valid   | o_in_ready   | i_in_data  (t_in_word)
// out     | o_out_valid  | i_out_ready  | o_out_data (t_out_word)
//
// One word at a time. Append, set and refused words go straight to the finish
// step; get passes through a get step (registered RAM read). Delete shifts the later
// entries down, one entry moved per cycle through the single RAM read port and write port.
// Synchronous active-low reset clears the count and the handshake state;
// RAM contents are not cleared. A held result does not block acceptance
// of the next word; that word waits in the finish step until the output frees.
module compacting_indexed_list_store
    import cilst_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned KW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_GET    = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_src, n_src;
    logic [AW-1:0]   r_dst, n_dst;
    logic            r_pend, n_pend;
    t_out_word       r_res, n_res;
    logic            r_out_valid, n_out_valid;
    t_out_word       r_out, n_out;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [VALUE_W-1:0] wdata;
    logic [AW-1:0]   raddr;
    logic [VALUE_W-1:0] rdata;

    logic            in_acc;
    logic [KW-1:0]   idx_x;
    logic [KW-1:0]   cnt_x;
    logic            out_free;

    cilst_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign idx_x       = KW'(i_in_data.index);
    assign cnt_x       = KW'(r_count);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_src       = r_src;
        n_dst       = r_dst;
        n_pend      = r_pend;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = idx_x[AW-1:0];
        wdata       = i_in_data.value;
        raddr       = idx_x[AW-1:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res.read_value = '0;
                    n_res.status     = ST_DONE;
                    n_state          = S_FINISH;
                    if (i_in_data.op == OP_APPEND) begin
                        if (r_count == CAP) begin
                            n_res.status = ST_FULL;
                        end else begin
                            we      = 1'b1;
                            waddr   = r_count[AW-1:0];
                            n_count = r_count + 1'b1;
                        end
                    end else if (idx_x >= cnt_x) begin
                        n_res.status = ST_RANGE;
                    end else if (i_in_data.op == OP_SET) begin
                        we = 1'b1;
                    end else if (i_in_data.op == OP_GET) begin
                        n_state = S_GET;
                    end else begin
                        n_src   = CW'(idx_x) + 1'b1;
                        n_pend  = 1'b0;
                        n_state = S_SHIFT;
                    end
                    n_res.count = COUNT_W'(n_count);
                end
            end
            S_GET: begin
                n_res.read_value = rdata;
                n_state          = S_FINISH;
            end
            S_SHIFT: begin
                we    = r_pend;
                waddr = r_dst;
                wdata = rdata;
                raddr = r_src[AW-1:0];
                if (r_src < r_count) begin
                    n_pend = 1'b1;
                    n_dst  = AW'(r_src - 1'b1);
                    n_src  = r_src + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count     = r_count - 1'b1;
                        n_res.count = COUNT_W'(r_count - 1'b1);
                        n_state     = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        r_dst <= n_dst;
        r_res <= n_res;
        r_out <= n_out;
    end

endmodule

// ===== sv/cilst_checker.sv =====
module cilst_checker
    import cilst_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_data
);

    localparam logic [COUNT_W-1:0] CAP7 = COUNT_W'(CAPACITY);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accepting a word");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_FULL) |-> (o_out_data.count == CAP7))
        else $error("full status with count below capacity");

    a_refused_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_DONE) |-> (o_out_data.read_value == '0))
        else $error("refused word returned data");

endmodule

bind compacting_indexed_list_store cilst_checker #(
    .CAPACITY(CAPACITY)
) u_cilst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

// ===== test/compacting_indexed_list_store_test.sv =====
`timescale 1ns / 100ps

module compacting_indexed_list_store_test;
    import cilst_pkg::*;

    localparam int unsigned CAPACITY   = 64;
    localparam int unsigned LAW        = $clog2(CAPACITY);
    localparam int unsigned MAX_CYCLES = 1_000_000;
    localparam int unsigned SETTLE     = 80;
    localparam int unsigned MAX_PRINTS = 40;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    compacting_indexed_list_store #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_word)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the list
    logic [VALUE_W-1:0] list_entries [CAPACITY];
    int unsigned        list_count     = 0;
    t_out_word          pending_results [$];

    int unsigned err_count      = 0;
    int unsigned words_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned full_refusals  = 0;
    int unsigned range_refusals = 0;
    int unsigned deletes_done   = 0;
    int unsigned cycle_count    = 0;
    int          hold_request   = 0;
    bit          tx_idle        = 1'b1;
    bit          rx_idle        = 1'b1;

    function automatic t_out_word apply_list_op(t_in_word w);
        t_out_word   r;
        int unsigned k;
        r        = '0;
        r.status = ST_DONE;
        if (w.op == OP_APPEND) begin
            if (list_count >= CAPACITY) begin
                r.status = ST_FULL;
                full_refusals++;
            end else begin
                list_entries[LAW'(list_count)] = w.value;
                list_count++;
            end
        end else if (int'(w.index) >= list_count) begin
            r.status = ST_RANGE;
            range_refusals++;
        end else if (w.op == OP_SET) begin
            list_entries[w.index] = w.value;
        end else if (w.op == OP_GET) begin
            r.read_value = list_entries[w.index];
        end else begin
            for (k = 32'(w.index); k + 1 < list_count; k++) begin
                list_entries[LAW'(k)] = list_entries[LAW'(k + 1)];
            end
            list_entries[LAW'(list_count - 1)] = '0;
            list_count--;
            deletes_done++;
        end
        r.count = COUNT_W'(list_count);
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_handle();
        if ($urandom_range(0, 15) == 0) begin
            return '0;
        end
        return {$urandom, $urandom};
    endfunction

    // mostly live positions, sometimes anything the field allows
    function automatic int unsigned pick_index();
        if (list_count > 0 && $urandom_range(0, 7) != 0) begin
            return $urandom_range(0, list_count - 1);
        end
        return $urandom_range(0, (1 << INDEX_W) - 1);
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("[%0t] mismatch on %s, result %0d: got %h want %h",
                     $realtime, what, results_seen, got, want);
        end
    endtask

    task automatic send_word(input logic [OP_W-1:0] op, input int unsigned idx,
                             input logic [VALUE_W-1:0] val);
        t_in_word w;
        w.op    = op;
        w.index = INDEX_W'(idx);
        w.value = val;
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(apply_list_op(w));
        words_sent++;
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        stop_sending();
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic send_random(input int unsigned grow_pct);
        if ($urandom_range(0, 99) < grow_pct) begin
            send_word(OP_APPEND, $urandom_range(0, 63), rand_handle());
        end else begin
            case ($urandom_range(0, 2))
                0: send_word(OP_SET, pick_index(), rand_handle());
                1: send_word(OP_GET, pick_index(), rand_handle());
                default: send_word(OP_DELETE, pick_index(), rand_handle());
            endcase
        end
    endtask

    task automatic test_directed();
        send_word(OP_GET,    0,  '0);
        send_word(OP_SET,    63, '1);
        send_word(OP_DELETE, 0,  '0);
        send_word(OP_APPEND, 0,  '0);
        send_word(OP_APPEND, 0,  '1);
        send_word(OP_APPEND, 0,  64'h5555_5555_5555_5555);
        send_word(OP_APPEND, 0,  64'hAAAA_AAAA_AAAA_AAAA);
        send_word(OP_GET,    0,  '0);
        send_word(OP_GET,    1,  '0);
        send_word(OP_GET,    3,  '0);
        send_word(OP_GET,    4,  '0);
        send_word(OP_SET,    0,  64'h8000_0000_0000_0001);
        send_word(OP_SET,    3,  '0);
        send_word(OP_GET,    0,  '0);
        send_word(OP_DELETE, 1,  '0);
        send_word(OP_GET,    1,  '0);
        send_word(OP_DELETE, 2,  '0);
        send_word(OP_GET,    2,  '0);
        send_word(OP_GET,    63, '0);
        send_word(OP_DELETE, 63, '1);
        send_word(OP_DELETE, 0,  '0);
        send_word(OP_DELETE, 0,  '0);
        send_word(OP_APPEND, 63, 64'd1);
        send_word(OP_GET,    0,  '1);
        wait_drained();
    endtask

    task automatic test_fill_to_capacity();
        while (list_count < CAPACITY) begin
            send_word(OP_APPEND, $urandom_range(0, 63), rand_handle());
        end
        repeat (4) send_word(OP_APPEND, $urandom_range(0, 63), rand_handle());
        send_word(OP_GET, CAPACITY - 1, '0);
        repeat (4) send_word(OP_SET, pick_index(), rand_handle());
        repeat (3) send_word(OP_GET, pick_index(), '0);
        while (list_count > 0) begin
            if ($urandom_range(0, 2) == 0) begin
                send_word(OP_GET, pick_index(), rand_handle());
            end
            send_word(OP_DELETE, pick_index(), rand_handle());
        end
        wait_drained();
    endtask

    task automatic test_random_mix(input int n, input int unsigned grow_pct);
        repeat (n) send_random(grow_pct);
        stop_sending();
    endtask

    // output held off while input keeps coming; then sender waits for all results
    task automatic test_output_backpressure();
        wait_drained();
        hold_request = 200;
        repeat (16) send_random(50);
        wait_drained();
    endtask

    initial begin : receiver
        int hold_len;
        forever begin
            @(posedge clk);
            if (hold_request > 0) begin
                hold_len     = hold_request;
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                out_ready <= 1'b1;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : check_results
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", out_word.read_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (out_word.read_value !== want.read_value) begin
                    report_mismatch("read_value", out_word.read_value, want.read_value);
                end
                if (out_word.status !== want.status) begin
                    report_mismatch("status", VALUE_W'(out_word.status),
                                    VALUE_W'(want.status));
                end
                if (out_word.count !== want.count) begin
                    report_mismatch("count", VALUE_W'(out_word.count),
                                    VALUE_W'(want.count));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_to_capacity();
        test_random_mix(400, 60);
        test_output_backpressure();
        test_random_mix(400, 25);
        wait_drained();
        test_random_mix(400, 45);

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_fill_to_capacity();
        test_random_mix(250, 50);

        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("%0d words sent, %0d results checked, %0d deletes with shift",
                 words_sent, results_seen, deletes_done);
        $display("%0d appends refused on a full store, %0d out-of-range indexes refused",
                 full_refusals, range_refusals);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
